/* rtl/core/shi_pkg.sv */
package shi_pkg;

    localparam int SHI_TABLE_DEPTH = 64;
    localparam int HASH_W          = 16;
    localparam int TAG_W           = 16;
    localparam int POS_W           = 6;
    localparam int ENTRY_W         = HASH_W + TAG_W;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SORT = 2'd1,
        OP_FIND = 2'd2,
        OP_NEXT = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [7:0]         key_byte;
        logic               last_byte;
        logic [TAG_W-1:0]   entry_tag;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [TAG_W-1:0]   tag;
        logic [POS_W-1:0]   position;
        logic               status;
    } t_out_word;

    typedef struct packed {
        logic               valid;
        t_out_word          word;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_CHK_CMP,
        ST_BACK,
        ST_BACK_CMP,
        ST_NEXT_CMP,
        ST_SORT_I,
        ST_SORT_HOLD,
        ST_SORT_J,
        ST_SORT_CMP
    } t_state;

endpackage

/* rtl/core/shi_ram.sv */
module shi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/shi_seq.sv */
module shi_seq import shi_pkg::*; #(
    parameter int TABLE_DEPTH = SHI_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = AW + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_in_word           i_word,
    output logic               o_idle,
    output t_result            o_result,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [ENTRY_W-1:0] o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr,
    input  logic [ENTRY_W-1:0] i_rdata
);

    t_state              r_state, n_state;
    logic [HASH_W-1:0]   r_sum, n_sum;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_cursor, n_cursor;
    logic                r_cur_valid, n_cur_valid;
    logic [HASH_W-1:0]   r_sought, n_sought;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [ENTRY_W-1:0]  r_hold, n_hold;

    logic [HASH_W-1:0]   sum_next;
    logic [HASH_W-1:0]   rd_hash;
    logic [CW:0]         mid_sum;
    logic [CW-1:0]       mid;
    logic [CW-1:0]       nxt;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       j_dec;
    logic                full;
    logic                next_ok;
    logic                equal;

    assign sum_next = r_sum + {8'd0, i_word.key_byte};
    assign rd_hash  = i_rdata[ENTRY_W-1:TAG_W];
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[CW:1];
    assign nxt      = {1'b0, r_cursor} + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign j_dec    = r_j - CW'(1);
    assign full     = r_count >= CW'(TABLE_DEPTH);
    assign next_ok  = r_cur_valid && (nxt < r_count);
    assign equal    = rd_hash == r_sought;
    assign o_idle   = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_word.operation) inside
                        OP_LOAD: n_state = ST_IDLE;
                        OP_FIND: n_state = i_word.last_byte ? ST_SRCH : ST_IDLE;
                        OP_SORT: n_state = ST_SORT_I;
                        OP_NEXT: n_state = next_ok ? ST_NEXT_CMP : ST_IDLE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = ST_SRCH_CMP;
                end else if (r_lo < r_count) begin
                    n_state = ST_CHK_CMP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SRCH_CMP:  n_state = ST_SRCH;
            ST_CHK_CMP:   n_state = equal ? ST_BACK : ST_IDLE;
            ST_BACK:      n_state = (r_idx == '0) ? ST_IDLE : ST_BACK_CMP;
            ST_BACK_CMP:  n_state = equal ? ST_BACK : ST_IDLE;
            ST_NEXT_CMP:  n_state = ST_IDLE;
            ST_SORT_I:    n_state = (r_i < r_count) ? ST_SORT_HOLD : ST_IDLE;
            ST_SORT_HOLD: n_state = ST_SORT_J;
            ST_SORT_J:    n_state = (r_j == '0) ? ST_SORT_I : ST_SORT_CMP;
            ST_SORT_CMP: begin
                n_state = (rd_hash > r_hold[ENTRY_W-1:TAG_W]) ? ST_SORT_J : ST_SORT_I;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sum       = r_sum;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_cur_valid = r_cur_valid;
        n_sought    = r_sought;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_hold      = r_hold;
        o_result    = '0;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_raddr     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_word.operation) inside
                        OP_LOAD, OP_FIND: begin
                            if (!i_word.last_byte) begin
                                n_sum = sum_next;
                            end else begin
                                n_sum = '0;
                                if (i_word.operation == OP_LOAD) begin
                                    o_result.valid = 1'b1;
                                    if (full) begin
                                        o_result.word.status = 1'b1;
                                    end else begin
                                        o_we    = 1'b1;
                                        o_waddr = r_count[AW-1:0];
                                        o_wdata = {sum_next, i_word.entry_tag};
                                        n_count = r_count + CW'(1);
                                    end
                                end else begin
                                    n_sought = sum_next;
                                    n_lo     = '0;
                                    n_hi     = r_count;
                                end
                            end
                        end
                        OP_SORT: begin
                            n_i         = CW'(1);
                            n_cur_valid = 1'b0;
                        end
                        OP_NEXT: begin
                            if (next_ok) begin
                                o_re    = 1'b1;
                                o_raddr = nxt[AW-1:0];
                                n_idx   = nxt;
                            end else begin
                                n_cur_valid    = 1'b0;
                                o_result.valid = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    o_re    = 1'b1;
                    o_raddr = mid[AW-1:0];
                    n_idx   = mid;
                end else if (r_lo < r_count) begin
                    o_re    = 1'b1;
                    o_raddr = r_lo[AW-1:0];
                    n_idx   = r_lo;
                end else begin
                    n_cur_valid    = 1'b0;
                    o_result.valid = 1'b1;
                end
            end
            ST_SRCH_CMP: begin
                if (rd_hash < r_sought) begin
                    n_lo = r_idx + CW'(1);
                end else begin
                    n_hi = r_idx;
                end
            end
            ST_CHK_CMP: begin
                if (equal) begin
                    n_hold = i_rdata;
                end else begin
                    n_cur_valid    = 1'b0;
                    o_result.valid = 1'b1;
                end
            end
            ST_BACK: begin
                if (r_idx != '0) begin
                    o_re    = 1'b1;
                    o_raddr = idx_dec[AW-1:0];
                end else begin
                    n_cursor                = r_idx[AW-1:0];
                    n_cur_valid             = 1'b1;
                    o_result.valid          = 1'b1;
                    o_result.word.found     = 1'b1;
                    o_result.word.tag       = r_hold[TAG_W-1:0];
                    o_result.word.position  = POS_W'(r_idx);
                end
            end
            ST_BACK_CMP: begin
                if (equal) begin
                    n_idx  = idx_dec;
                    n_hold = i_rdata;
                end else begin
                    // first equal hash is the one held from the last step
                    n_cursor                = r_idx[AW-1:0];
                    n_cur_valid             = 1'b1;
                    o_result.valid          = 1'b1;
                    o_result.word.found     = 1'b1;
                    o_result.word.tag       = r_hold[TAG_W-1:0];
                    o_result.word.position  = POS_W'(r_idx);
                end
            end
            ST_NEXT_CMP: begin
                o_result.valid = 1'b1;
                if (equal) begin
                    n_cursor               = r_idx[AW-1:0];
                    o_result.word.found    = 1'b1;
                    o_result.word.tag      = i_rdata[TAG_W-1:0];
                    o_result.word.position = POS_W'(r_idx);
                end else begin
                    n_cur_valid = 1'b0;
                end
            end
            ST_SORT_I: begin
                if (r_i < r_count) begin
                    o_re    = 1'b1;
                    o_raddr = r_i[AW-1:0];
                end else begin
                    o_result.valid = 1'b1;
                end
            end
            ST_SORT_HOLD: begin
                n_hold = i_rdata;
                n_j    = r_i;
            end
            ST_SORT_J: begin
                if (r_j == '0) begin
                    o_we    = 1'b1;
                    o_waddr = r_j[AW-1:0];
                    o_wdata = r_hold;
                    n_i     = r_i + CW'(1);
                end else begin
                    o_re    = 1'b1;
                    o_raddr = j_dec[AW-1:0];
                end
            end
            ST_SORT_CMP: begin
                o_we    = 1'b1;
                o_waddr = r_j[AW-1:0];
                // shift the larger entry up, else drop the held entry in
                if (rd_hash > r_hold[ENTRY_W-1:TAG_W]) begin
                    o_wdata = i_rdata;
                    n_j     = j_dec;
                end else begin
                    o_wdata = r_hold;
                    n_i     = r_i + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_sought    <= '0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_cur_valid <= n_cur_valid;
            r_sought    <= n_sought;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_idx  <= n_idx;
        r_i    <= n_i;
        r_j    <= n_j;
        r_hold <= n_hold;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_cursor_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> ({1'b0, r_cursor} < r_count))
        else $error("valid cursor outside loaded entries");

    a_idle_result_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && r_state == ST_IDLE) |-> i_start)
        else $error("result from idle without an accepted word");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && r_state == ST_IDLE) |-> !full)
        else $error("load written into a full table");

endmodule

/* rtl/core/sorted_hash_index_lookup.sv */
// channel | valid      | ready       | word
// --------+------------+-------------+------------
// input   | i_in_valid | o_in_ready  | i_in_word
// output  | o_out_valid| i_out_ready | o_out_word
//
// bytes that are not last and loads are handled in idle; the sequencer stays idle
// find: each binary search step, the hit check and each preceding equal hash
// take a read and a compare, all set by the registered read of the single table ram
// find next: a read and a compare; sort: insertion sort, each entry read and held,
// each larger entry before it shifted up, then the held entry written in place
// reset clears the entry count, sum and cursor; the ram needs no clearing
// input is ready when the sequencer is idle and the output register is free
module sorted_hash_index_lookup import shi_pkg::*; #(
    parameter int TABLE_DEPTH = SHI_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic               idle;
    logic               start;
    t_result            result;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic               r_out_valid, n_out_valid;
    t_out_word          r_out_word, n_out_word;

    assign o_in_ready = idle && (!r_out_valid || i_out_ready);
    assign start      = i_in_valid && o_in_ready;

    shi_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_word   (i_in_word),
        .o_idle   (idle),
        .o_result (result),
        .o_we     (mem_we),
        .o_waddr  (mem_waddr),
        .o_wdata  (mem_wdata),
        .o_re     (mem_re),
        .o_raddr  (mem_raddr),
        .i_rdata  (mem_rdata)
    );

    shi_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;
        if (result.valid) begin
            n_out_valid = 1'b1;
            n_out_word  = result.word;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* verif/sorted_hash_index_lookup_tb.sv */
module sorted_hash_index_lookup_tb;
    import shi_pkg::*;

    localparam int DEPTH = SHI_TABLE_DEPTH;
    localparam int STALL_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    sorted_hash_index_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [15:0] key_sum;
    int          n_entries;
    logic [15:0] hashes [DEPTH];
    logic [15:0] tags [DEPTH];
    int          cursor;
    bit          cursor_ok;
    logic [15:0] target_hash;

    t_out_word lookup_q[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  quiet_cycles = 0;

    function automatic void predict_word(input t_in_word w);
        t_out_word r;
        logic [15:0] h, th, tt;
        int lo, hi, mid, j, nxt;
        r = '0;
        h = key_sum + {8'd0, w.key_byte};
        case (w.operation)
            OP_LOAD, OP_FIND: begin
                if (!w.last_byte) begin
                    key_sum = h;
                    return;
                end
                key_sum = '0;
                if (w.operation == OP_LOAD) begin
                    if (n_entries >= DEPTH) begin
                        r.status = 1'b1;
                    end else begin
                        hashes[n_entries] = h;
                        tags[n_entries] = w.entry_tag;
                        n_entries++;
                    end
                end else begin
                    target_hash = h;
                    lo = 0;
                    hi = n_entries;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (hashes[mid] < h) lo = mid + 1;
                        else hi = mid;
                    end
                    if (lo < n_entries && hashes[lo] == h) begin
                        while (lo > 0 && hashes[lo-1] == h) lo--;
                        cursor = lo;
                        cursor_ok = 1'b1;
                        r.found = 1'b1;
                        r.tag = tags[lo];
                        r.position = lo[5:0];
                    end else begin
                        cursor_ok = 1'b0;
                    end
                end
            end
            OP_SORT: begin
                for (int i = 1; i < n_entries; i++) begin
                    th = hashes[i];
                    tt = tags[i];
                    j = i;
                    while (j > 0 && hashes[j-1] > th) begin
                        hashes[j] = hashes[j-1];
                        tags[j] = tags[j-1];
                        j--;
                    end
                    hashes[j] = th;
                    tags[j] = tt;
                end
                cursor_ok = 1'b0;
            end
            default: begin
                nxt = cursor + 1;
                if (cursor_ok && nxt < n_entries && hashes[nxt] == target_hash) begin
                    cursor = nxt;
                    r.found = 1'b1;
                    r.tag = tags[nxt];
                    r.position = nxt[5:0];
                end else begin
                    cursor_ok = 1'b0;
                end
            end
        endcase
        lookup_q.push_back(r);
    endfunction

    // valid stays up after acceptance; an idle gap before the next send or a drain takes it down
    task automatic send_word(input t_op op, input logic [7:0] kb, input bit last,
                             input logic [15:0] etag);
        t_in_word w;
        bit rdy;
        w.operation = op;
        w.key_byte = kb;
        w.last_byte = last;
        w.entry_tag = etag;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        // ready sampled mid cycle holds its value at the next edge
        do begin
            @(negedge i_clk);
            rdy = o_in_ready;
            @(posedge i_clk);
        end while (!rdy);
        predict_word(w);
    endtask

    // key of random length aimed at a chosen sum
    task automatic send_key(input t_op op, input logic [15:0] hv, input logic [15:0] etag);
        int len;
        logic [15:0] acc;
        logic [7:0] b;
        len = $urandom_range(3);
        acc = '0;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            send_word(op, b, 1'b0, 16'($urandom));
            acc += b;
        end
        // last byte may not reach the sum exactly; hash is whatever results
        b = hv[7:0] - acc[7:0];
        send_word(op, b, 1'b1, etag);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge i_clk);
    endtask

    // result check
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lookup_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = lookup_q.pop_front();
                if (o_out_word.found !== e.found) begin
                    $error("found exp %0h got %0h", e.found, o_out_word.found); errors++;
                end
                if (o_out_word.tag !== e.tag) begin
                    $error("tag exp %0h got %0h", e.tag, o_out_word.tag); errors++;
                end
                if (o_out_word.position !== e.position) begin
                    $error("position exp %0h got %0h", e.position, o_out_word.position);
                    errors++;
                end
                if (o_out_word.status !== e.status) begin
                    $error("status exp %0h got %0h", e.status, o_out_word.status); errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || recv_hold) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reset_model();
        key_sum = '0;
        n_entries = 0;
        cursor = 0;
        cursor_ok = 1'b0;
        target_hash = '0;
    endtask

    task automatic test_directed();
        send_word(OP_NEXT, 8'h00, 1'b0, 16'h0000);
        send_word(OP_FIND, 8'hff, 1'b1, 16'hffff);
        send_word(OP_LOAD, 8'hff, 1'b0, 16'h0000);
        send_word(OP_LOAD, 8'hff, 1'b1, 16'hffff);
        send_word(OP_LOAD, 8'h05, 1'b1, 16'h1111);
        send_word(OP_LOAD, 8'h05, 1'b1, 16'h2222);
        send_word(OP_LOAD, 8'h00, 1'b1, 16'h0000);
        // unsorted search
        send_word(OP_FIND, 8'h05, 1'b1, 16'h0);
        send_word(OP_SORT, 8'hff, 1'b1, 16'hffff);
        send_word(OP_FIND, 8'h05, 1'b1, 16'h0);
        send_word(OP_NEXT, 8'h00, 1'b1, 16'h0);
        send_word(OP_NEXT, 8'h00, 1'b1, 16'h0);
        // mixed key bytes share the sum
        send_word(OP_LOAD, 8'h01, 1'b0, 16'h0);
        send_word(OP_FIND, 8'h04, 1'b1, 16'h0);
        send_word(OP_NEXT, 8'h00, 1'b0, 16'h0);
        send_word(OP_FIND, 8'hff, 1'b0, 16'h0);
        send_word(OP_FIND, 8'hff, 1'b0, 16'h0);
        send_word(OP_FIND, 8'h00, 1'b1, 16'h0);
        drain_results();
    endtask

    // fill past full with many equal hashes, then sort and walk the run
    task automatic test_full_table();
        for (int i = 0; i < DEPTH + 3; i++)
            send_key(OP_LOAD, 16'($urandom_range(7)), 16'($urandom));
        send_word(OP_SORT, 8'h0, 1'b0, 16'h0);
        for (int i = 0; i < 8; i++) begin
            send_key(OP_FIND, 16'(i), 16'h0);
            for (int k = 0; k < 10; k++)
                send_word(OP_NEXT, 8'($urandom), 1'($urandom), 16'($urandom));
        end
        drain_results();
    endtask

    task automatic test_random(input int n_ops);
        int pick;
        for (int i = 0; i < n_ops; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) send_key(OP_LOAD, 16'($urandom_range(15)), 16'($urandom));
            else if (pick < 35) send_word(OP_SORT, 8'($urandom), 1'($urandom), 16'($urandom));
            else if (pick < 65) send_key(OP_FIND, 16'($urandom_range(15)), 16'($urandom));
            else if (pick < 90) send_word(OP_NEXT, 8'($urandom), 1'($urandom), 16'($urandom));
            else send_word(t_op'($urandom_range(3)), 8'($urandom), 1'($urandom),
                           16'($urandom));
        end
        drain_results();
    endtask

    // receiver held off while the sender keeps offering words
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++) send_key(OP_FIND, 16'($urandom_range(15)), 16'h0);
        join
        drain_results();
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 8;
        recv_idle_pct = 60;
        test_directed();
        test_full_table();
        test_backpressure();
        // table stays full from here on, so loads report full
        send_idle_pct = 60;
        recv_idle_pct = 8;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(350);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
